FILE: rtl/core/typed_integer_alu_macros.svh
// Assertion macros used by the typed integer ALU RTL.
`ifndef TYPED_INTEGER_ALU_MACROS_SVH
`define TYPED_INTEGER_ALU_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define TIA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("typed_integer_alu: assertion failed");

// Next-cycle implication.
`define TIA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("typed_integer_alu: assertion failed");

`endif

FILE: rtl/core/tia_pkg.sv
// Opcodes, control struct and default widths for the typed integer ALU.
`timescale 1ns / 1ps

package tia_pkg;

	localparam int WIDE_BITS_DEF   = 32;
	localparam int NARROW_BITS_DEF = 8;
	localparam int OPERAND_BITS    = 32;

	typedef enum logic [3:0] {
		OP_ADD = 4'd0,
		OP_SUB = 4'd1,
		OP_MUL = 4'd2,
		OP_DIV = 4'd3,
		OP_MOD = 4'd4,
		OP_POW = 4'd5,
		OP_GT  = 4'd6,
		OP_LT  = 4'd7,
		OP_EQ  = 4'd8,
		OP_NEQ = 4'd9,
		OP_LEQ = 4'd10,
		OP_GEQ = 4'd11
	} opcode_t;

	// Per-item control that rides along the divide/power stages.
	typedef struct packed {
		logic [3:0] op;
		logic       narrow;
		logic       div_err;   // zero divisor
		logic       q_neg;     // quotient sign
		logic       r_neg;     // remainder sign
		logic       p_neg;     // power result sign
		logic       p_spec;    // power answered without iteration
	} ctl_t;

endpackage

FILE: rtl/core/typed_integer_alu.sv
// Typed integer ALU: top level with operand prep, stage chain and result register.
//
// Request channel: req_valid / req_stall carry operation, width_sel, operand_a
// and operand_b. A transfer happens on a rising edge with req_valid high and
// req_stall low. Response channel: rsp_valid / rsp_stall carry result and
// error_flag under the same rule.
// Every operation goes through the same pipeline: an operand register, a setup
// stage, one stage per bit of the internal width (max of WIDE_BITS and
// NARROW_BITS) that each retire one restoring-divide quotient bit and, in the
// first clog2 stages, one exponent bit of square-and-multiply, then the result
// register. One item per cycle is sustained while rsp_stall does not hold the
// pipe; the divide chain sets the depth.
// Reset clears every valid bit; the pipe comes up empty and ready.
// While a response waits under rsp_stall the whole pipe holds and req_stall is
// raised, so nothing is dropped or repeated; a bubble-free pipe resumes at
// full rate as soon as rsp_stall drops.
`timescale 1ns / 1ps
`include "typed_integer_alu_macros.svh"

module typed_integer_alu #(
	parameter int WIDE_BITS   = tia_pkg::WIDE_BITS_DEF,
	parameter int NARROW_BITS = tia_pkg::NARROW_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [3:0]  operation,
	input  logic        width_sel,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic signed [31:0] result,
	output logic        error_flag
);

	localparam int DW  = (WIDE_BITS > NARROW_BITS) ? WIDE_BITS : NARROW_BITS;
	localparam int LOG = $clog2(DW);
	localparam int OB  = tia_pkg::OPERAND_BITS;

	// Reduce a DW-bit pattern to the selected width and sign-extend it back.
	function automatic logic [DW-1:0] fit(input logic [DW-1:0] v, input logic nar);
		logic [DW-1:0] o;
		for (int i = 0; i < DW; i++) begin
			if (nar)
				o[i] = (i < NARROW_BITS) ? v[i] : v[NARROW_BITS-1];
			else
				o[i] = (i < WIDE_BITS) ? v[i] : v[WIDE_BITS-1];
		end
		return o;
	endfunction

	function automatic logic [DW-1:0] widen(input logic [OB-1:0] v);
		logic [DW-1:0] o;
		for (int i = 0; i < DW; i++)
			o[i] = (i < OB) ? v[i] : v[OB-1];
		return o;
	endfunction

	// Take a value already fitted to DW bits into the 32-bit result field.
	function automatic logic [OB-1:0] to_field(input logic [DW-1:0] v);
		logic [OB-1:0] o;
		for (int i = 0; i < OB; i++)
			o[i] = (i < DW) ? v[i] : v[DW-1];
		return o;
	endfunction

	logic en;
	assign en        = !(rsp_valid && rsp_stall);
	assign req_stall = rsp_valid && rsp_stall;

	// Operand register
	logic          v_s1;
	logic [3:0]    op_s1;
	logic          nar_s1;
	logic [DW-1:0] a_s1;
	logic [DW-1:0] b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1  <= operation;
			nar_s1 <= width_sel;
			a_s1   <= fit(widen(operand_a), width_sel);
			b_s1   <= fit(widen(operand_b), width_sel);
		end
	end

	// Setup stage
	logic          a_neg, b_neg, odd;
	logic          a_zero, a_one, a_mone, b_zero, b_ge_w;
	logic [DW-1:0] mag_a, mag_b, simple, spec_val, half, lim;
	logic [2*DW-1:0] prod;
	tia_pkg::ctl_t ctl_n;
	logic [DW-1:0] fixed_n;

	always_comb begin
		a_neg  = a_s1[DW-1];
		b_neg  = b_s1[DW-1];
		odd    = b_s1[0];
		mag_a  = a_neg ? (~a_s1 + 1'b1) : a_s1;
		mag_b  = b_neg ? (~b_s1 + 1'b1) : b_s1;
		a_zero = (a_s1 == '0);
		a_one  = (a_s1 == DW'(1));
		a_mone = (a_s1 == '1);
		b_zero = (b_s1 == '0);
		b_ge_w = nar_s1 ? (b_s1 >= DW'(NARROW_BITS)) : (b_s1 >= DW'(WIDE_BITS));
		half   = nar_s1 ? (DW'(1) << (NARROW_BITS - 1)) : (DW'(1) << (WIDE_BITS - 1));
		prod   = a_s1 * b_s1;

		ctl_n.op      = op_s1;
		ctl_n.narrow  = nar_s1;
		ctl_n.div_err = b_zero;
		ctl_n.q_neg   = a_neg ^ b_neg;
		ctl_n.r_neg   = a_neg;
		ctl_n.p_neg   = a_neg && odd;
		ctl_n.p_spec  = b_zero || a_one || a_mone || b_neg || a_zero;
		lim           = half - DW'(!(a_neg && odd));

		// Trivial power answers: zero exponent, unit bases, negative exponents, zero base.
		priority if (b_zero || a_one) spec_val = DW'(1);
		else if (a_mone)             spec_val = odd ? '1 : DW'(1);
		else                         spec_val = '0;

		simple = '0;
		unique case (tia_pkg::opcode_t'(op_s1))
			tia_pkg::OP_ADD: simple = fit(a_s1 + b_s1, nar_s1);
			tia_pkg::OP_SUB: simple = fit(a_s1 - b_s1, nar_s1);
			tia_pkg::OP_MUL: simple = fit(prod[DW-1:0], nar_s1);
			tia_pkg::OP_GT:  simple = DW'($signed(a_s1) > $signed(b_s1));
			tia_pkg::OP_LT:  simple = DW'($signed(a_s1) < $signed(b_s1));
			tia_pkg::OP_EQ:  simple = DW'(a_s1 == b_s1);
			tia_pkg::OP_NEQ: simple = DW'(a_s1 != b_s1);
			tia_pkg::OP_LEQ: simple = DW'($signed(a_s1) <= $signed(b_s1));
			tia_pkg::OP_GEQ: simple = DW'($signed(a_s1) >= $signed(b_s1));
			default:         simple = '0;
		endcase
		fixed_n = (op_s1 == tia_pkg::OP_POW) ? spec_val : simple;
	end

	logic          v_s2;
	tia_pkg::ctl_t ctl_s2;
	logic [DW-1:0] fixed_s2;
	logic [DW-1:0] mag_a_s2;
	logic [DW-1:0] mag_b_s2;
	logic [DW-1:0] lim_s2;
	logic [LOG-1:0] exp_s2;
	logic          ovf_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s2   <= ctl_n;
			fixed_s2 <= fixed_n;
			mag_a_s2 <= mag_a;
			mag_b_s2 <= mag_b;
			lim_s2   <= lim;
			exp_s2   <= b_s1[LOG-1:0];
			ovf_s2   <= b_ge_w;
		end
	end

	logic [DW:0]           v_c;
	tia_pkg::ctl_t         ctl_c   [DW+1];
	logic [DW-1:0]         fixed_c [DW+1];
	logic [DW-1:0]         rem_c   [DW+1];
	logic [DW-1:0]         quo_c   [DW+1];
	logic [DW-1:0]         dvs_c   [DW+1];
	logic [DW-1:0]         acc_c   [DW+1];
	logic [DW-1:0]         base_c  [DW+1];
	logic [DW-1:0]         lim_c   [DW+1];
	logic [LOG-1:0]        exp_c   [DW+1];
	logic [DW:0]           ovf_c;
	logic [DW:0]           bovf_c;

	assign v_c[0]     = v_s2;
	assign ctl_c[0]   = ctl_s2;
	assign fixed_c[0] = fixed_s2;
	assign rem_c[0]   = '0;
	assign quo_c[0]   = mag_a_s2;
	assign dvs_c[0]   = mag_b_s2;
	assign acc_c[0]   = DW'(1);
	assign base_c[0]  = mag_a_s2;
	assign lim_c[0]   = lim_s2;
	assign exp_c[0]   = exp_s2;
	assign ovf_c[0]   = ovf_s2;
	assign bovf_c[0]  = 1'b0;

	generate
		for (genvar k = 0; k < DW; k++) begin : g_stage
			tia_stage #(.DW(DW), .LOG(LOG), .IDX(k)) u_stage (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (en),
				.valid_i (v_c[k]),
				.ctl_i   (ctl_c[k]),
				.fixed_i (fixed_c[k]),
				.rem_i   (rem_c[k]),
				.quo_i   (quo_c[k]),
				.dvs_i   (dvs_c[k]),
				.acc_i   (acc_c[k]),
				.base_i  (base_c[k]),
				.lim_i   (lim_c[k]),
				.exp_i   (exp_c[k]),
				.ovf_i   (ovf_c[k]),
				.bovf_i  (bovf_c[k]),
				.valid_o (v_c[k+1]),
				.ctl_o   (ctl_c[k+1]),
				.fixed_o (fixed_c[k+1]),
				.rem_o   (rem_c[k+1]),
				.quo_o   (quo_c[k+1]),
				.dvs_o   (dvs_c[k+1]),
				.acc_o   (acc_c[k+1]),
				.base_o  (base_c[k+1]),
				.lim_o   (lim_c[k+1]),
				.exp_o   (exp_c[k+1]),
				.ovf_o   (ovf_c[k+1]),
				.bovf_o  (bovf_c[k+1])
			);
		end
	endgenerate

	// Result assembly
	tia_pkg::ctl_t ctl_l;
	logic [DW-1:0] pmag, fin;
	logic          err_n;

	always_comb begin
		ctl_l = ctl_c[DW];
		pmag  = ovf_c[DW] ? lim_c[DW] : acc_c[DW];
		err_n = 1'b0;
		unique case (tia_pkg::opcode_t'(ctl_l.op))
			tia_pkg::OP_DIV: begin
				fin   = ctl_l.div_err ? '0
				      : (ctl_l.q_neg ? (~quo_c[DW] + 1'b1) : quo_c[DW]);
				err_n = ctl_l.div_err;
			end
			tia_pkg::OP_MOD: begin
				fin   = ctl_l.div_err ? '0
				      : (ctl_l.r_neg ? (~rem_c[DW] + 1'b1) : rem_c[DW]);
				err_n = ctl_l.div_err;
			end
			tia_pkg::OP_POW: begin
				fin   = ctl_l.p_spec ? fixed_c[DW]
				      : (ctl_l.p_neg ? (~pmag + 1'b1) : pmag);
				err_n = !ctl_l.p_spec && ovf_c[DW];
			end
			default: fin = fixed_c[DW];
		endcase
	end

	logic        rsp_valid_q;
	logic [31:0] result_q;
	logic        error_q;
	logic [3:0]  rsp_op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			rsp_valid_q <= v_c[DW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_q <= to_field(fit(fin, ctl_l.narrow));
			error_q  <= err_n;
			rsp_op_q <= ctl_l.op;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign result     = result_q;
	assign error_flag = error_q;

	// Error only comes from divide, remainder or power.
	`TIA_ASSERT_NOW(a_err_src, clk, arst_n, rsp_valid && error_flag,
		rsp_op_q == tia_pkg::OP_DIV || rsp_op_q == tia_pkg::OP_MOD || rsp_op_q == tia_pkg::OP_POW)
	// Comparisons answer 0 or 1.
	`TIA_ASSERT_NOW(a_cmp_bool, clk, arst_n, rsp_valid && rsp_op_q >= tia_pkg::OP_GT,
		result[31:1] == 31'd0)
	// A zero-divisor error always reports a zero result.
	`TIA_ASSERT_NOW(a_div_zero, clk, arst_n,
		rsp_valid && error_flag && (rsp_op_q == tia_pkg::OP_DIV || rsp_op_q == tia_pkg::OP_MOD),
		result == 32'sd0)
	// A stalled response freezes the last stage of the chain.
	`TIA_ASSERT_NEXT(a_hold, clk, arst_n, rsp_valid && rsp_stall, $stable(v_c[DW]))

endmodule

FILE: rtl/core/tia_stage.sv
// One pipeline stage: a restoring divide step and, in early stages, a power step.
`timescale 1ns / 1ps

module tia_stage #(
	parameter int DW  = 32,
	parameter int LOG = 5,
	parameter int IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              valid_i,
	input  tia_pkg::ctl_t     ctl_i,
	input  logic [DW-1:0]     fixed_i,
	input  logic [DW-1:0]     rem_i,
	input  logic [DW-1:0]     quo_i,
	input  logic [DW-1:0]     dvs_i,
	input  logic [DW-1:0]     acc_i,
	input  logic [DW-1:0]     base_i,
	input  logic [DW-1:0]     lim_i,
	input  logic [LOG-1:0]    exp_i,
	input  logic              ovf_i,
	input  logic              bovf_i,
	output logic              valid_o,
	output tia_pkg::ctl_t     ctl_o,
	output logic [DW-1:0]     fixed_o,
	output logic [DW-1:0]     rem_o,
	output logic [DW-1:0]     quo_o,
	output logic [DW-1:0]     dvs_o,
	output logic [DW-1:0]     acc_o,
	output logic [DW-1:0]     base_o,
	output logic [DW-1:0]     lim_o,
	output logic [LOG-1:0]    exp_o,
	output logic              ovf_o,
	output logic              bovf_o
);

	logic [DW:0]   rem_sh;
	logic [DW:0]   rem_sub;
	logic [DW-1:0] rem_n;
	logic [DW-1:0] quo_n;
	logic [DW-1:0] acc_n;
	logic [DW-1:0] base_n;
	logic          ovf_n;
	logic          bovf_n;

	// Shift in the next dividend bit, subtract when the divisor fits.
	always_comb begin
		rem_sh  = {rem_i, quo_i[DW-1]};
		rem_sub = rem_sh - {1'b0, dvs_i};
		quo_n   = {quo_i[DW-2:0], 1'b0};
		rem_n   = rem_sh[DW-1:0];
		if (rem_sh >= {1'b0, dvs_i}) begin
			rem_n    = rem_sub[DW-1:0];
			quo_n[0] = 1'b1;
		end
	end

	generate
		if (IDX < LOG) begin : g_pow
			logic [2*DW-1:0] prod_acc;
			logic [2*DW-1:0] prod_base;

			// Square-and-multiply on one exponent bit, saturating against the limit.
			always_comb begin
				prod_acc  = acc_i * base_i;
				prod_base = base_i * base_i;
				acc_n     = acc_i;
				ovf_n     = ovf_i;
				base_n    = base_i;
				bovf_n    = bovf_i;
				if (exp_i[IDX] && !ovf_i) begin
					if (bovf_i || prod_acc > {{DW{1'b0}}, lim_i})
						ovf_n = 1'b1;
					else
						acc_n = prod_acc[DW-1:0];
				end
				if (!bovf_i) begin
					if (prod_base > {{DW{1'b0}}, lim_i})
						bovf_n = 1'b1;
					else
						base_n = prod_base[DW-1:0];
				end
			end
		end else begin : g_hold
			always_comb begin
				acc_n  = acc_i;
				base_n = base_i;
				ovf_n  = ovf_i;
				bovf_n = bovf_i;
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (en) begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_o   <= ctl_i;
			fixed_o <= fixed_i;
			rem_o   <= rem_n;
			quo_o   <= quo_n;
			dvs_o   <= dvs_i;
			acc_o   <= acc_n;
			base_o  <= base_n;
			lim_o   <= lim_i;
			exp_o   <= exp_i;
			ovf_o   <= ovf_n;
			bovf_o  <= bovf_n;
		end
	end

endmodule
